// ===== rtl/core/gbi_pkg.sv =====
// Shared types, constants and helpers of the grid bilinear interpolator.
package gbi_pkg;

  localparam int unsigned MAX_ROWS = 128;
  localparam int unsigned MAX_COLS = 128;

  localparam int unsigned ROW_W = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 2;
  localparam int unsigned COL_W = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 2;
  localparam int unsigned IDX_W = (ROW_W > COL_W) ? ROW_W : COL_W;

  localparam int unsigned BANK_AW    = (ROW_W - 1) + (COL_W - 1);
  localparam int unsigned BANK_DEPTH = 2 ** BANK_AW;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned SIZE_W = 8;

  localparam int unsigned D_W    = 33;
  localparam int unsigned P_W    = 50;
  localparam int unsigned W_FULL = P_W + 1;
  localparam int unsigned W_W    = 32;
  localparam int          W_LIMIT = 1073741824;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_FIRST_MIN  = 3'd0,
    CFG_SECOND_MIN = 3'd1,
    CFG_FIRST_INV  = 3'd2,
    CFG_SECOND_INV = 3'd3,
    CFG_ROWS       = 3'd4,
    CFG_COLS       = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    cmd_e                      command;
    logic [6:0]                write_row;
    logic [6:0]                write_col;
    logic signed [DATA_W-1:0]  write_value;
    logic signed [DATA_W-1:0]  query_first;
    logic signed [DATA_W-1:0]  query_second;
  } gbi_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  interpolated;
    logic                      saturated_flag;
  } gbi_result_t;

  function automatic logic [IDX_W-1:0] size_limit(input logic [SIZE_W-1:0] sz,
                                                  input int unsigned max_n);
    int unsigned s;
    s = 32'(sz);
    if (s < 2) begin
      s = 2;
    end else if (s > max_n) begin
      s = max_n;
    end
    return IDX_W'(s - 2);
  endfunction

endpackage

// ===== rtl/core/gbi_if.sv =====
// Valid/ready channel interfaces for the interpolator's items and results.
interface gbi_item_if;
  import gbi_pkg::*;
  logic      valid;
  logic      ready;
  gbi_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gbi_result_if;
  import gbi_pkg::*;
  logic        valid;
  logic        ready;
  gbi_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/gbi_axis.sv =====
// Four-stage axis locator: offset, scale by reciprocal step, cell index and weight.
module gbi_axis (
  input  logic                             clk_i,
  input  logic [3:0]                       en_i,
  input  logic signed [gbi_pkg::DATA_W-1:0] coord_i,
  input  logic signed [gbi_pkg::DATA_W-1:0] min_i,
  input  logic [gbi_pkg::DATA_W-1:0]       inv_i,
  input  logic [gbi_pkg::IDX_W-1:0]        lim_i,
  output logic [gbi_pkg::IDX_W-1:0]        idx_o,
  output logic signed [gbi_pkg::W_W-1:0]   w_o
);
  import gbi_pkg::*;

  localparam logic signed [W_FULL-1:0] W_POS = W_FULL'(W_LIMIT);
  localparam logic signed [W_FULL-1:0] W_NEG = -W_POS;

  logic signed [D_W-1:0]    d_q;
  logic signed [P_W-1:0]    ph_q;
  logic signed [P_W-1:0]    pl_q;
  logic signed [P_W-1:0]    p_q;
  logic signed [P_W-1:0]    raw;
  logic signed [W_FULL-1:0] wfull;
  logic [IDX_W-1:0]         idx_d;
  logic signed [W_W-1:0]    w_d;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d_q <= {coord_i[DATA_W-1], coord_i} - {min_i[DATA_W-1], min_i};
    end
    if (en_i[1]) begin
      ph_q <= d_q * $signed({1'b0, inv_i[31:16]});
      pl_q <= d_q * $signed({1'b0, inv_i[15:0]});
    end
    if (en_i[2]) begin
      p_q <= ph_q + (pl_q >>> 16);
    end
    if (en_i[3]) begin
      idx_o <= idx_d;
      w_o   <= w_d;
    end
  end

  always_comb begin
    raw = p_q >>> 16;
    if (raw < 0) begin
      idx_d = '0;
    end else if (raw > $signed(P_W'(lim_i))) begin
      idx_d = lim_i;
    end else begin
      idx_d = raw[IDX_W-1:0];
    end
    wfull = $signed({p_q[P_W-1], p_q}) - $signed(W_FULL'({idx_d, 16'b0}));
    if (wfull > W_POS) begin
      w_d = W_W'(W_POS);
    end else if (wfull < W_NEG) begin
      w_d = W_W'(W_NEG);
    end else begin
      w_d = W_W'(wfull);
    end
  end

endmodule

// ===== rtl/core/gbi_grid_ram.sv =====
// Grid storage in four banks split by row and column parity, one read each per cycle while rd_en_i is high.
module gbi_grid_ram (
  input  logic                                clk_i,
  input  logic                                rd_en_i,
  input  logic [gbi_pkg::ROW_W-1:0]           rd_row_i,
  input  logic [gbi_pkg::COL_W-1:0]           rd_col_i,
  input  logic                                we_i,
  input  logic [gbi_pkg::ROW_W-1:0]           wr_row_i,
  input  logic [gbi_pkg::COL_W-1:0]           wr_col_i,
  input  logic [gbi_pkg::DATA_W-1:0]          wr_data_i,
  output logic [3:0][gbi_pkg::DATA_W-1:0]     rdata_o
);
  import gbi_pkg::*;

  logic [ROW_W-1:0]   row_next;
  logic [COL_W-1:0]   col_next;
  logic [BANK_AW-1:0] waddr;

  assign row_next = rd_row_i + ROW_W'(1);
  assign col_next = rd_col_i + COL_W'(1);
  assign waddr    = {wr_row_i[ROW_W-1:1], wr_col_i[COL_W-1:1]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [DATA_W-1:0]  mem [BANK_DEPTH];
    logic [ROW_W-1:0]   r;
    logic [COL_W-1:0]   c;
    logic [BANK_AW-1:0] raddr;
    logic               wsel;

    assign r     = (rd_row_i[0] == b[1]) ? rd_row_i : row_next;
    assign c     = (rd_col_i[0] == b[0]) ? rd_col_i : col_next;
    assign raddr = {r[ROW_W-1:1], c[COL_W-1:1]};
    assign wsel  = we_i && (wr_row_i[0] == b[1]) && (wr_col_i[0] == b[0]);

    always_ff @(posedge clk_i) begin
      if (wsel) begin
        mem[waddr] <= wr_data_i;
      end
      if (rd_en_i) begin
        rdata_o[b] <= mem[raddr];
      end
    end
  end

endmodule

// ===== rtl/core/grid_bilinear_interpolator_unit.sv =====
// Top level of the grid bilinear interpolator: control pipeline, lerp stages, configuration.
//
// Items arrive on item_i. A write item stores write_value at (write_row, write_col)
// and gives no result; a query item gives one result on result_o, in order.
// Configuration registers are written through cfg_we_i, cfg_idx_i and cfg_data_i,
// one register per cycle; the user must do so only while no item is in flight,
// which the block does not enforce. The block is a 13-stage pipeline: four stages
// locate the cell on both axes, one stage reads the four neighbors from four parity
// banks, and eight stages do the column lerps, the row lerp and the saturation. One
// item is accepted every cycle unless a stall on result_o holds item_i.ready low.
// A write lands in its bank in the fifth stage, so any later query sees it.
// Each stage holds while the one after it is full and stalled, so a stall on
// result_o fills the empty stages first and then holds item_i.ready low; no
// item is lost or repeated. Reset clears all valid bits and sets the
// registers to their defaults; the grid itself is not cleared and must be
// written before it is queried.
module grid_bilinear_interpolator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gbi_item_if.sink                      item_i,
  gbi_result_if.source                  result_o,
  input  logic                          cfg_we_i,
  input  logic [gbi_pkg::CFG_AW-1:0]    cfg_idx_i,
  input  logic [gbi_pkg::DATA_W-1:0]    cfg_data_i
);
  import gbi_pkg::*;

  localparam int unsigned NSTG  = 13;
  localparam int unsigned Y_W   = DATA_W + 1;
  localparam int unsigned YP_W  = Y_W + W_W;
  localparam int unsigned M_W   = YP_W - 16;
  localparam int unsigned V_W   = 50;
  localparam int unsigned DV_W  = V_W + 1;
  localparam int unsigned DL_W  = 25;
  localparam int unsigned DH_W  = DV_W - DL_W;
  localparam int unsigned XP_W  = DH_W + W_W;
  localparam int unsigned F_W   = XP_W + DL_W + 1;
  localparam logic signed [F_W-1:0] V_MAX = F_W'(32'sh7FFF_FFFF);
  localparam logic signed [F_W-1:0] V_MIN = F_W'($signed(32'h8000_0000));

  logic [DATA_W-1:0] first_min_q, second_min_q, first_inv_q, second_inv_q;
  logic [SIZE_W-1:0] rows_q, cols_q;
  logic [IDX_W-1:0]  row_lim, col_lim;

  logic [NSTG:1]     vld_q, vld_d;
  logic [NSTG+1:1]   rdy;

  cmd_e              cmd_q  [1:4];
  logic              wok_q  [1:4];
  logic [6:0]        wrow_q [1:4];
  logic [6:0]        wcol_q [1:4];
  logic [DATA_W-1:0] wval_q [1:4];

  logic [IDX_W-1:0]        row_idx, col_idx;
  logic signed [W_W-1:0]   wx4, wy4;
  logic [3:0][DATA_W-1:0]  rdata;
  logic                    ram_we;

  logic                    s5_i0_q, s5_j0_q;
  logic signed [W_W-1:0]   s5_wx_q, s5_wy_q, s6_wx_q, s6_wy_q, s7_wx_q, s8_wx_q, s9_wx_q;
  logic signed [DATA_W-1:0] g00, g01, g10, g11;
  logic signed [DATA_W-1:0] s6_g00_q, s6_g10_q, s7_g00_q, s7_g10_q;
  logic signed [Y_W-1:0]   s6_dy0_q, s6_dy1_q;
  logic signed [YP_W-1:0]  yp0, yp1;
  logic signed [M_W-1:0]   s7_m0_q, s7_m1_q;
  logic signed [V_W-1:0]   s8_v0_q, s8_v1_q, s9_v0_q, s10_v0_q, s11_v0_q;
  logic signed [DV_W-1:0]  s9_dv_q;
  logic signed [XP_W-1:0]  s10_xph_q, s10_xpl_q;
  logic signed [F_W-1:0]   s11_full_q, s12_v_q;
  logic signed [DATA_W-1:0] s13_val_q;
  logic                    s13_sat_q;

  assign row_lim = size_limit(rows_q, MAX_ROWS);
  assign col_lim = size_limit(cols_q, MAX_COLS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_min_q  <= '0;
      second_min_q <= '0;
      first_inv_q  <= 32'd65536;
      second_inv_q <= 32'd65536;
      rows_q       <= 8'd128;
      cols_q       <= 8'd128;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_FIRST_MIN:  first_min_q  <= cfg_data_i;
        CFG_SECOND_MIN: second_min_q <= cfg_data_i;
        CFG_FIRST_INV:  first_inv_q  <= cfg_data_i;
        CFG_SECOND_INV: second_inv_q <= cfg_data_i;
        CFG_ROWS:       rows_q       <= cfg_data_i[SIZE_W-1:0];
        CFG_COLS:       cols_q       <= cfg_data_i[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rdy[NSTG+1] = result_o.ready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_d[1] = item_i.valid;
    for (int k = 2; k <= NSTG; k++) begin
      vld_d[k] = vld_q[k-1];
    end
    vld_d[5] = vld_q[4] && (cmd_q[4] == CMD_QUERY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  assign item_i.ready   = rdy[1];
  assign result_o.valid = vld_q[NSTG];
  assign result_o.data  = '{interpolated: s13_val_q, saturated_flag: s13_sat_q};

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      cmd_q[1]  <= item_i.data.command;
      wok_q[1]  <= (32'(item_i.data.write_row) < MAX_ROWS) &&
                   (32'(item_i.data.write_col) < MAX_COLS);
      wrow_q[1] <= item_i.data.write_row;
      wcol_q[1] <= item_i.data.write_col;
      wval_q[1] <= item_i.data.write_value;
    end
    for (int k = 2; k <= 4; k++) begin
      if (rdy[k]) begin
        cmd_q[k]  <= cmd_q[k-1];
        wok_q[k]  <= wok_q[k-1];
        wrow_q[k] <= wrow_q[k-1];
        wcol_q[k] <= wcol_q[k-1];
        wval_q[k] <= wval_q[k-1];
      end
    end
  end

  gbi_axis u_axis_row (
    .clk_i   (clk_i),
    .en_i    (rdy[4:1]),
    .coord_i (item_i.data.query_first),
    .min_i   ($signed(first_min_q)),
    .inv_i   (first_inv_q),
    .lim_i   (row_lim),
    .idx_o   (row_idx),
    .w_o     (wx4)
  );

  gbi_axis u_axis_col (
    .clk_i   (clk_i),
    .en_i    (rdy[4:1]),
    .coord_i (item_i.data.query_second),
    .min_i   ($signed(second_min_q)),
    .inv_i   (second_inv_q),
    .lim_i   (col_lim),
    .idx_o   (col_idx),
    .w_o     (wy4)
  );

  assign ram_we = rdy[5] && vld_q[4] && (cmd_q[4] == CMD_WRITE) && wok_q[4];

  gbi_grid_ram u_grid_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rdy[5]),
    .rd_row_i  (ROW_W'(row_idx)),
    .rd_col_i  (COL_W'(col_idx)),
    .we_i      (ram_we),
    .wr_row_i  (ROW_W'(wrow_q[4])),
    .wr_col_i  (COL_W'(wcol_q[4])),
    .wr_data_i (wval_q[4]),
    .rdata_o   (rdata)
  );

  assign g00 = $signed(rdata[{s5_i0_q, s5_j0_q}]);
  assign g01 = $signed(rdata[{s5_i0_q, !s5_j0_q}]);
  assign g10 = $signed(rdata[{!s5_i0_q, s5_j0_q}]);
  assign g11 = $signed(rdata[{!s5_i0_q, !s5_j0_q}]);

  assign yp0 = s6_dy0_q * s6_wy_q;
  assign yp1 = s6_dy1_q * s6_wy_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      s5_i0_q <= row_idx[0];
      s5_j0_q <= col_idx[0];
      s5_wx_q <= wx4;
      s5_wy_q <= wy4;
    end
    if (rdy[6]) begin
      s6_g00_q <= g00;
      s6_g10_q <= g10;
      s6_dy0_q <= Y_W'(g01) - Y_W'(g00);
      s6_dy1_q <= Y_W'(g11) - Y_W'(g10);
      s6_wx_q  <= s5_wx_q;
      s6_wy_q  <= s5_wy_q;
    end
    if (rdy[7]) begin
      s7_m0_q  <= yp0[YP_W-1:16];
      s7_m1_q  <= yp1[YP_W-1:16];
      s7_g00_q <= s6_g00_q;
      s7_g10_q <= s6_g10_q;
      s7_wx_q  <= s6_wx_q;
    end
    if (rdy[8]) begin
      s8_v0_q <= V_W'(s7_g00_q) + V_W'(s7_m0_q);
      s8_v1_q <= V_W'(s7_g10_q) + V_W'(s7_m1_q);
      s8_wx_q <= s7_wx_q;
    end
    if (rdy[9]) begin
      s9_dv_q <= DV_W'(s8_v1_q) - DV_W'(s8_v0_q);
      s9_v0_q <= s8_v0_q;
      s9_wx_q <= s8_wx_q;
    end
    if (rdy[10]) begin
      s10_xph_q <= $signed(s9_dv_q[DV_W-1:DL_W]) * s9_wx_q;
      s10_xpl_q <= $signed({1'b0, s9_dv_q[DL_W-1:0]}) * s9_wx_q;
      s10_v0_q  <= s9_v0_q;
    end
    if (rdy[11]) begin
      s11_full_q <= (F_W'(s10_xph_q) <<< DL_W) + F_W'(s10_xpl_q);
      s11_v0_q   <= s10_v0_q;
    end
    if (rdy[12]) begin
      s12_v_q <= F_W'(s11_v0_q) + (s11_full_q >>> 16);
    end
    if (rdy[13]) begin
      if (s12_v_q > V_MAX) begin
        s13_val_q <= DATA_W'(V_MAX);
        s13_sat_q <= 1'b1;
      end else if (s12_v_q < V_MIN) begin
        s13_val_q <= DATA_W'(V_MIN);
        s13_sat_q <= 1'b1;
      end else begin
        s13_val_q <= DATA_W'(s12_v_q);
        s13_sat_q <= 1'b0;
      end
    end
  end

endmodule

// ===== dv/tb_grid_bilinear_interpolator_unit.sv =====
// Testbench of the grid bilinear interpolator: stimulus, prediction and result checking.
`timescale 1ns / 1ps

module tb_grid_bilinear_interpolator_unit;
  import gbi_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int    PIPE_SETTLE  = 20;
  localparam wide_t WEIGHT_LIMIT = 128'sd1073741824;
  localparam wide_t RESULT_MAX   = 128'sd2147483647;
  localparam wide_t RESULT_MIN   = -128'sd2147483648;

  logic        clk;
  logic        rst_ni;
  logic        cfg_we;
  cfg_reg_e    cfg_idx;
  logic [31:0] cfg_data;

  gbi_item_if   item_bus ();
  gbi_result_if result_bus ();

  grid_bilinear_interpolator_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .item_i     (item_bus),
    .result_o   (result_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  logic [31:0] first_min_q  = 32'h0;
  logic [31:0] second_min_q = 32'h0;
  logic [31:0] first_inv_q  = 32'h0001_0000;
  logic [31:0] second_inv_q = 32'h0001_0000;
  logic [7:0]  rows_q       = 8'd128;
  logic [7:0]  cols_q       = 8'd128;

  logic [31:0] grid_model  [MAX_ROWS * MAX_COLS];
  bit          grid_filled [MAX_ROWS * MAX_COLS];

  gbi_result_t pending_results [$];
  int          error_count;
  int          burst_left;
  int          rx_cycle;
  int          rx_mode;
  int          hold_off_until;

  always #2 clk = ~clk;

  function automatic int size_clamp(input logic [7:0] s, input int max_n);
    int n;
    n = s;
    if (n < 2) n = 2;
    else if (n > max_n) n = max_n;
    return n;
  endfunction

  function automatic void locate_axis(input logic [31:0] coord, input logic [31:0] axis_min,
                                      input logic [31:0] inv_step, input int n,
                                      output int cell_idx, output wide_t weight);
    wide_t offset;
    wide_t base;
    wide_t pos;
    wide_t whole;
    offset = $signed(coord);
    base   = $signed(axis_min);
    offset = offset - base;
    pos    = (offset * $signed({96'd0, inv_step})) >>> 16;
    whole  = pos >>> 16;
    if (whole < 0) whole = 0;
    else if (whole > n - 2) whole = n - 2;
    weight = pos - (whole <<< 16);
    if (weight > WEIGHT_LIMIT) weight = WEIGHT_LIMIT;
    else if (weight < -WEIGHT_LIMIT) weight = -WEIGHT_LIMIT;
    cell_idx = int'(whole);
  endfunction

  function automatic wide_t cell_value(input int r, input int c);
    wide_t v;
    v = $signed(grid_model[r * MAX_COLS + c]);
    return v;
  endfunction

  function automatic wide_t lerp(input wide_t a, input wide_t b, input wide_t w);
    return a + (((b - a) * w) >>> 16);
  endfunction

  function automatic gbi_result_t predict_bilinear(input logic [31:0] qf, input logic [31:0] qs);
    int          r;
    int          c;
    wide_t       wx;
    wide_t       wy;
    wide_t       v0;
    wide_t       v1;
    wide_t       v;
    gbi_result_t res;
    locate_axis(qf, first_min_q, first_inv_q, size_clamp(rows_q, MAX_ROWS), r, wx);
    locate_axis(qs, second_min_q, second_inv_q, size_clamp(cols_q, MAX_COLS), c, wy);
    v0 = lerp(cell_value(r, c), cell_value(r, c + 1), wy);
    v1 = lerp(cell_value(r + 1, c), cell_value(r + 1, c + 1), wy);
    v  = lerp(v0, v1, wx);
    res.saturated_flag = 1'b0;
    if (v > RESULT_MAX) begin
      v = RESULT_MAX;
      res.saturated_flag = 1'b1;
    end else if (v < RESULT_MIN) begin
      v = RESULT_MIN;
      res.saturated_flag = 1'b1;
    end
    res.interpolated = v[31:0];
    return res;
  endfunction

  function automatic gbi_item_t noise_item();
    gbi_item_t it;
    it.command      = cmd_e'($urandom_range(0, 1));
    it.write_row    = 7'($urandom);
    it.write_col    = 7'($urandom);
    it.write_value  = $urandom;
    it.query_first  = $urandom;
    it.query_second = $urandom;
    return it;
  endfunction

  function automatic logic [31:0] coord_for(input logic [31:0] axis_min,
                                            input logic [31:0] inv_step, input int n);
    int unsigned sel;
    longint      cells;
    longint      off;
    sel = $urandom_range(0, 9);
    if (sel == 9) return $urandom;
    if (sel < 3) cells = longint'($urandom_range(0, n - 1)) <<< 16;
    else cells = longint'($urandom_range(0, (n + 2) * 65536)) - 65536;
    off = (inv_step == 0) ? cells : (cells <<< 16) / longint'(inv_step);
    return 32'(longint'($signed(axis_min)) + off);
  endfunction

  task automatic send_item(input gbi_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item_bus.valid <= 1'b1;
    item_bus.data  <= it;
    do @(posedge clk); while (!item_bus.ready);
    if (it.command == CMD_WRITE) begin
      grid_model[int'(it.write_row) * MAX_COLS + it.write_col]  = it.write_value;
      grid_filled[int'(it.write_row) * MAX_COLS + it.write_col] = 1'b1;
    end else begin
      pending_results.push_back(predict_bilinear(it.query_first, it.query_second));
    end
    @(negedge clk);
  endtask

  task automatic store_point(input int row, input int col, input logic [31:0] value);
    gbi_item_t it;
    it             = noise_item();
    it.command     = CMD_WRITE;
    it.write_row   = 7'(row);
    it.write_col   = 7'(col);
    it.write_value = value;
    send_item(it);
  endtask

  // Neighbors that were never written are stored first, so no query reads an empty entry.
  task automatic query_point(input logic [31:0] qf, input logic [31:0] qs);
    int        r;
    int        c;
    wide_t     wr;
    wide_t     wc;
    gbi_item_t it;
    locate_axis(qf, first_min_q, first_inv_q, size_clamp(rows_q, MAX_ROWS), r, wr);
    locate_axis(qs, second_min_q, second_inv_q, size_clamp(cols_q, MAX_COLS), c, wc);
    for (int dr = 0; dr < 2; dr++) begin
      for (int dc = 0; dc < 2; dc++) begin
        if (!grid_filled[(r + dr) * MAX_COLS + c + dc]) begin
          store_point(r + dr, c + dc, $urandom);
        end
      end
    end
    it              = noise_item();
    it.command      = CMD_QUERY;
    it.query_first  = qf;
    it.query_second = qs;
    send_item(it);
  endtask

  task automatic stop_items;
    item_bus.valid <= 1'b0;
  endtask

  task automatic wait_idle;
    stop_items();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (PIPE_SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      CFG_FIRST_MIN:  first_min_q  = value;
      CFG_SECOND_MIN: second_min_q = value;
      CFG_FIRST_INV:  first_inv_q  = value;
      CFG_SECOND_INV: second_inv_q = value;
      CFG_ROWS:       rows_q       = value[7:0];
      CFG_COLS:       cols_q       = value[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [31:0] fmin, input logic [31:0] smin,
                               input logic [31:0] finv, input logic [31:0] sinv,
                               input logic [31:0] rows_word, input logic [31:0] cols_word);
    write_reg(CFG_FIRST_MIN, fmin);
    write_reg(CFG_SECOND_MIN, smin);
    write_reg(CFG_FIRST_INV, finv);
    write_reg(CFG_SECOND_INV, sinv);
    write_reg(CFG_ROWS, rows_word);
    write_reg(CFG_COLS, cols_word);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] random_size_word();
    int unsigned sel;
    logic [7:0]  s;
    sel = $urandom_range(0, 9);
    if (sel < 6) s = 8'($urandom_range(2, 8));
    else if (sel < 7) s = 8'd128;
    else if (sel < 8) s = 8'd2;
    else s = 8'($urandom_range(0, 255));
    return {($urandom_range(0, 1) == 0) ? 24'h0 : 24'($urandom), s};
  endfunction

  task automatic random_settings;
    logic [31:0] fmin;
    logic [31:0] smin;
    logic [31:0] finv;
    logic [31:0] sinv;
    if ($urandom_range(0, 3) != 0) begin
      fmin = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      smin = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      finv = $urandom_range(32'h0000_1000, 32'h0010_0000);
      sinv = $urandom_range(32'h0000_1000, 32'h0010_0000);
    end else begin
      fmin = $urandom;
      smin = $urandom;
      finv = $urandom;
      sinv = $urandom;
    end
    load_settings(fmin, smin, finv, sinv, random_size_word(), random_size_word());
  endtask

  task automatic random_item;
    int rows_n;
    int cols_n;
    rows_n = size_clamp(rows_q, MAX_ROWS);
    cols_n = size_clamp(cols_q, MAX_COLS);
    if ($urandom_range(0, 9) < 3) begin
      if ($urandom_range(0, 1) == 0) begin
        store_point($urandom_range(0, rows_n - 1), $urandom_range(0, cols_n - 1), $urandom);
      end else begin
        store_point($urandom_range(0, 127), $urandom_range(0, 127), $urandom);
      end
    end else begin
      query_point(coord_for(first_min_q, first_inv_q, rows_n),
                  coord_for(second_min_q, second_inv_q, cols_n));
    end
  endtask

  task automatic test_directed_extremes;
    load_settings(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'd4, 32'd4);
    store_point(0, 0, 32'h7FFF_FFFF);
    store_point(0, 1, 32'h8000_0000);
    store_point(1, 0, 32'h8000_0000);
    store_point(1, 1, 32'h7FFF_FFFF);
    store_point(127, 127, 32'h0001_8000);
    store_point(127, 0, 32'h0);
    store_point(0, 127, 32'hFFFF_0000);
    query_point(32'h0, 32'h0);
    query_point(32'h0000_8000, 32'h0000_8000);
    query_point(32'h0000_4000, 32'h0);
    query_point(32'h8000_0000, 32'h0);
    query_point(32'h0, 32'h8000_0000);
    query_point(32'h8000_0000, 32'h8000_0000);
    query_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    query_point(32'h0002_C000, 32'hFFFF_0000);
    wait_idle();
  endtask

  task automatic test_size_registers;
    load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFF);
    query_point(32'h0, 32'h0);
    query_point(32'h7FFF_FFFF, 32'h8000_0000);
    query_point(32'h8000_0000, 32'h7FFF_FFFF);
    wait_idle();
    load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'h81);
    query_point(32'h0, 32'h0);
    query_point(32'h7FFF_FFFF, 32'h8000_0000);
    query_point(32'h8000_0000, 32'h7FFF_FFFF);
    wait_idle();
    load_settings(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'd128, 32'd2);
    query_point(32'h007E_8000, 32'h0000_8000);
    query_point(32'h007F_0000, 32'h0001_0000);
    wait_idle();
  endtask

  task automatic test_random_phases;
    for (int phase = 0; phase < 10; phase++) begin
      random_settings();
      repeat (100) random_item();
      wait_idle();
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall the sender.
  task automatic test_backpressure;
    load_settings(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'd8, 32'd8);
    hold_off_until = rx_cycle + 300;
    repeat (80) random_item();
    wait_idle();
  endtask

  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 160 == 0) begin
      rx_mode <= $urandom_range(0, 2);
    end
    if (rx_cycle < hold_off_until) begin
      result_bus.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: result_bus.ready <= 1'b1;
        1: result_bus.ready <= ($urandom_range(0, 9) >= 3);
        default: result_bus.ready <= ((rx_cycle % 11) >= 4);
      endcase
    end
  end

  always @(posedge clk) begin
    gbi_result_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: actual %h flag %0b", $time,
                 result_bus.data.interpolated, result_bus.data.saturated_flag);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_bus.data.interpolated !== want.interpolated) begin
          $display("%0t interpolated mismatch: expected %h actual %h", $time,
                   want.interpolated, result_bus.data.interpolated);
          error_count++;
        end
        if (result_bus.data.saturated_flag !== want.saturated_flag) begin
          $display("%0t saturated_flag mismatch: expected %0b actual %0b", $time,
                   want.saturated_flag, result_bus.data.saturated_flag);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    clk              = 1'b0;
    rst_ni           = 1'b0;
    item_bus.valid   = 1'b0;
    item_bus.data    = '0;
    result_bus.ready = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_FIRST_MIN;
    cfg_data         = '0;
    error_count      = 0;
    burst_left       = 0;
    rx_cycle         = 0;
    rx_mode          = 0;
    hold_off_until   = 0;
    repeat (10) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);
    test_directed_extremes();
    test_size_registers();
    test_random_phases();
    test_backpressure();
    wait_idle();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
